[design/dosq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dosq_pkg
// Shared widths, codes and types for the dual-order service queue.
// ----------------------------------------------------------------------------
package dosq_pkg;

   localparam int CAPACITY_DEF    = 64;
   localparam int AMOUNT_BITS_DEF = 20;
   localparam int QUEUE_DEPTH     = 2;

   localparam int KIND_W   = 2;
   localparam int AMOUNT_W = 20;
   localparam int NUMBER_W = 32;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_ARRIVE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SERVE_OLD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SERVE_MAX  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOP        = 2'd3;

   localparam logic [STATUS_W-1:0] ST_SERVED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   typedef enum logic [1:0] {
      OP_ARRIVE,
      OP_SERVE_OLD,
      OP_SERVE_MAX
   } dosq_op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_MOVE
   } dosq_state_type;

endpackage
`default_nettype wire

[design/dual_order_service_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_order_service_queue_unit
// Waiting-entry store served either oldest-first or largest-amount-first.
//
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_kind, req_amount
// rsp      out        rsp_valid/rsp_stall   rsp_served_number, rsp_status
//
// Arrive: no response unless the store is full.
// Serve: one read per entry through the single store read port and comparator,
// then one drain step and one removal step (states BK_DRAIN and BK_MOVE).
// Synchronous active-high reset empties the store and restarts numbering at 1.
// A two-entry command queue keeps taking requests while the engine is busy
// until it fills; a stalled response holds in its output register.
// ----------------------------------------------------------------------------
module dual_order_service_queue_unit #(
   parameter int CAPACITY    = dosq_pkg::CAPACITY_DEF,
   parameter int AMOUNT_BITS = dosq_pkg::AMOUNT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [dosq_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [dosq_pkg::AMOUNT_W-1:0]   req_amount,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [dosq_pkg::NUMBER_W-1:0]        rsp_served_number,
   output logic [dosq_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int OP_W = $bits(dosq_pkg::dosq_op_type);
   localparam int Q_W  = OP_W + AMOUNT_BITS;

   logic                        q_push;
   logic                        q_full;
   logic                        q_pop;
   logic                        q_empty;
   dosq_pkg::dosq_op_type       push_op;
   logic [AMOUNT_BITS-1:0]      push_amount;
   logic [Q_W-1:0]              q_rdata;
   dosq_pkg::dosq_op_type       cmd_op;

   dosq_front #(
      .AMOUNT_BITS (AMOUNT_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_amount (req_amount),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (push_op),
      .q_amount   (push_amount)
   );

   dosq_cmd_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata ({push_op, push_amount}),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd_op = dosq_pkg::dosq_op_type'(q_rdata[Q_W-1:AMOUNT_BITS]);

   dosq_back #(
      .CAPACITY    (CAPACITY),
      .AMOUNT_BITS (AMOUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (!q_empty),
      .cmd_op            (cmd_op),
      .cmd_amount        (q_rdata[AMOUNT_BITS-1:0]),
      .cmd_pop           (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_served_number (rsp_served_number),
      .rsp_status        (rsp_status)
   );

   // a served transaction always carries a real arrival number
   a_served_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dosq_pkg::ST_SERVED) |-> rsp_served_number != '0)
      else $error("served response with zero number");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dosq_pkg::ST_SERVED) |-> rsp_served_number == '0)
      else $error("error response with nonzero number");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("engine popped an empty command queue");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
`default_nettype wire

[design/dosq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dosq_front
// Request decode: classifies each transaction and pushes work into the queue.
// ----------------------------------------------------------------------------
module dosq_front #(
   parameter int AMOUNT_BITS = dosq_pkg::AMOUNT_BITS_DEF
) (
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dosq_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [dosq_pkg::AMOUNT_W-1:0] req_amount,
   input  wire logic                          q_full,
   output logic                               q_push,
   output dosq_pkg::dosq_op_type              q_op,
   output logic [AMOUNT_BITS-1:0]             q_amount
);

   logic [AMOUNT_BITS+dosq_pkg::AMOUNT_W-1:0] amount_ext;
   logic                                      is_work;

   assign req_stall  = q_full;
   assign amount_ext = {{AMOUNT_BITS{1'b0}}, req_amount};
   assign q_amount   = amount_ext[AMOUNT_BITS-1:0];

   always_comb begin
      q_op    = dosq_pkg::OP_ARRIVE;
      is_work = 1'b1;
      unique case (req_kind)
         dosq_pkg::KIND_ARRIVE:    q_op = dosq_pkg::OP_ARRIVE;
         dosq_pkg::KIND_SERVE_OLD: q_op = dosq_pkg::OP_SERVE_OLD;
         dosq_pkg::KIND_SERVE_MAX: q_op = dosq_pkg::OP_SERVE_MAX;
         default:                  is_work = 1'b0;   // no-op kind is dropped
      endcase
   end

   assign q_push = req_valid && !q_full && is_work;

endmodule
`default_nettype wire

[design/dosq_cmd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dosq_cmd_queue
// Small register queue decoupling request decode from the service engine.
// ----------------------------------------------------------------------------
module dosq_cmd_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int DEPTH = dosq_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

[design/dosq_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dosq_back
// Service engine: entry store, sequential scan with one shared comparator,
// removal by moving the last entry into the freed slot, response register.
// ----------------------------------------------------------------------------
module dosq_back #(
   parameter int CAPACITY    = dosq_pkg::CAPACITY_DEF,
   parameter int AMOUNT_BITS = dosq_pkg::AMOUNT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cmd_valid,
   input  wire dosq_pkg::dosq_op_type           cmd_op,
   input  wire logic [AMOUNT_BITS-1:0]          cmd_amount,
   output logic                                 cmd_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [dosq_pkg::NUMBER_W-1:0]        rsp_served_number,
   output logic [dosq_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int NUM_W  = dosq_pkg::NUMBER_W;
   localparam int WORD_W = AMOUNT_BITS + NUM_W;

   // live entries always sit in slots 0 .. occupancy-1
   logic [WORD_W-1:0] mem [CAPACITY];

   dosq_pkg::dosq_state_type state_ff, state_in;

   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [NUM_W-1:0]    next_num_ff, next_num_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                serve_max_ff, serve_max_in;
   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [WORD_W-1:0]   rdata_ff;
   logic [AMOUNT_BITS-1:0] best_amt_ff;
   logic [NUM_W-1:0]    best_num_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]    rsp_num_ff;
   logic [dosq_pkg::STATUS_W-1:0] rsp_st_ff;

   logic                slot_free;
   logic                is_full;
   logic                is_empty;
   logic [IDX_W-1:0]    last_idx;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic                rd_en;
   logic                rd_cmp;
   logic [IDX_W-1:0]    rd_addr;
   logic                start_scan;
   logic                do_arrive;
   logic                do_remove;
   logic                load_rsp;
   logic [NUM_W-1:0]    load_num;
   logic [dosq_pkg::STATUS_W-1:0] load_st;
   logic [AMOUNT_BITS-1:0] rd_amt;
   logic [NUM_W-1:0]    rd_num;
   logic                better;
   logic                take;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (occ_ff == OCC_W'(CAPACITY)) || (next_num_ff == '0);
   assign is_empty  = (occ_ff == '0);
   assign last_idx  = IDX_W'(occ_ff - OCC_W'(1));

   assign rd_num = rdata_ff[NUM_W-1:0];
   assign rd_amt = rdata_ff[WORD_W-1:NUM_W];

   always_comb begin
      if (serve_max_ff) begin
         better = (rd_amt > best_amt_ff) ||
                  ((rd_amt == best_amt_ff) && (rd_num < best_num_ff));
      end else begin
         better = (rd_num < best_num_ff);
      end
   end

   assign take = cmp_vld_ff && ((cmp_idx_ff == '0) || better);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dosq_pkg::BK_IDLE: begin
            if (start_scan) begin
               state_in = dosq_pkg::BK_SCAN;
            end
         end
         dosq_pkg::BK_SCAN: begin
            if (scan_idx_ff == last_idx) begin
               state_in = dosq_pkg::BK_DRAIN;
            end
         end
         dosq_pkg::BK_DRAIN: state_in = dosq_pkg::BK_MOVE;
         dosq_pkg::BK_MOVE:  state_in = dosq_pkg::BK_IDLE;
         default:            state_in = dosq_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = best_idx_ff;
      mem_wdata  = rdata_ff;
      rd_en      = 1'b0;
      rd_cmp     = 1'b0;
      rd_addr    = scan_idx_ff;
      start_scan = 1'b0;
      do_arrive  = 1'b0;
      do_remove  = 1'b0;
      load_rsp   = 1'b0;
      load_num   = '0;
      load_st    = dosq_pkg::ST_SERVED;
      unique case (state_ff)
         dosq_pkg::BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               if (cmd_op == dosq_pkg::OP_ARRIVE) begin
                  if (is_full) begin
                     load_rsp = 1'b1;
                     load_st  = dosq_pkg::ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = IDX_W'(occ_ff);
                     mem_wdata = {cmd_amount, next_num_ff};
                     do_arrive = 1'b1;
                  end
               end else if (is_empty) begin
                  load_rsp = 1'b1;
                  load_st  = dosq_pkg::ST_EMPTY;
               end else begin
                  start_scan = 1'b1;
               end
            end
         end
         dosq_pkg::BK_SCAN: begin
            rd_en  = 1'b1;
            rd_cmp = 1'b1;
         end
         dosq_pkg::BK_DRAIN: begin
            // last compare runs now; fetch the tail entry for the move
            rd_en   = 1'b1;
            rd_addr = last_idx;
         end
         dosq_pkg::BK_MOVE: begin
            mem_we    = 1'b1;
            do_remove = 1'b1;
            load_rsp  = 1'b1;
            load_num  = best_num_ff;
            load_st   = dosq_pkg::ST_SERVED;
         end
         default: ;
      endcase
   end

   always_comb begin
      occ_in       = occ_ff;
      next_num_in  = next_num_ff;
      scan_idx_in  = scan_idx_ff;
      serve_max_in = serve_max_ff;
      if (do_arrive) begin
         occ_in      = occ_ff + OCC_W'(1);
         next_num_in = next_num_ff + NUM_W'(1);
      end else if (do_remove) begin
         occ_in = occ_ff - OCC_W'(1);
      end
      if (start_scan) begin
         scan_idx_in  = '0;
         serve_max_in = (cmd_op == dosq_pkg::OP_SERVE_MAX);
      end else if (rd_cmp) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dosq_pkg::BK_IDLE;
         occ_ff       <= '0;
         next_num_ff  <= NUM_W'(1);
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         next_num_ff  <= next_num_in;
         cmp_vld_ff   <= rd_cmp;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      serve_max_ff <= serve_max_in;
      cmp_idx_ff   <= rd_addr;
      if (take) begin
         best_amt_ff <= rd_amt;
         best_num_ff <= rd_num;
         best_idx_ff <= cmp_idx_ff;
      end
      if (load_rsp) begin
         rsp_num_ff <= load_num;
         rsp_st_ff  <= load_st;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_served_number = rsp_num_ff;
   assign rsp_status        = rsp_st_ff;

endmodule
`default_nettype wire
